@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// Each property is sampled on i_clk and ignored while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_IMPL(label, cond, expr)
`endif
`endif

@@ design/dtds_pkg.sv @@
// ----------------------------------------------------------------------------
// dtds_pkg
// Types and constants of the task-graph scheduler.
// ----------------------------------------------------------------------------
package dtds_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int NODE_COUNT_MAX = 64;

    typedef enum logic [2:0] {
        MODE_CLEAR    = 3'd0,
        MODE_SET_PRIO = 3'd1,
        MODE_ADD_EDGE = 3'd2,
        MODE_SUBMIT   = 3'd3,
        MODE_DISPATCH = 3'd4,
        MODE_RUN      = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CYCLE   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REACH,
        S_RELEASE
    } t_state;

    typedef struct packed {
        logic [2:0]        mode;
        logic [3:0]        node;
        logic [3:0]        other_node;
        logic signed [7:0] priority_req;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [3:0] out_node;
        logic       out_valid;
    } t_result;

    // Broadcast controls to the node cells.
    typedef struct packed {
        logic clr;
        logic set_prio;
        logic add_edge;
        logic set_done;
        logic q_clr;
        logic dec;
        logic q_set;
    } t_cell_ctl;

    // Broadcast controls to the queue cells.
    typedef struct packed {
        logic ins;
        logic rm_head;
        logic rm_node;
    } t_queue_ctl;

endpackage

@@ design/dtds_node_cell.sv @@
// ----------------------------------------------------------------------------
// dtds_node_cell
// One node of the graph: outgoing edge row, pending count, flags, priority.
// ----------------------------------------------------------------------------
module dtds_node_cell #(
    parameter int NODE_COUNT = dtds_pkg::NODE_COUNT_DEF,
    parameter int IDX        = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtds_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(NODE_COUNT)-1:0] i_sel,
    input  logic [$clog2(NODE_COUNT)-1:0] i_col,
    input  logic signed [7:0]             i_prio,
    input  logic                          i_reach_bit,
    input  logic [NODE_COUNT-1:0]         i_acc,
    output logic [NODE_COUNT-1:0]         o_acc,
    output logic [NODE_COUNT-1:0]         o_row,
    output logic [3:0]                    o_pend,
    output logic                          o_done,
    output logic                          o_queued,
    output logic signed [7:0]             o_prio
);
    localparam int IW = $clog2(NODE_COUNT);

    logic [NODE_COUNT-1:0] r_row, n_row;
    logic [3:0]            r_pend, n_pend;
    logic                  r_done, n_done;
    logic                  r_queued, n_queued;
    logic signed [7:0]     r_prio, n_prio;
    logic                  sel_me, col_me;

    assign sel_me = (i_sel == IW'(IDX));
    assign col_me = (i_col == IW'(IDX));

    // The reach word ripples down the row of cells.
    assign o_acc = i_acc | (i_reach_bit ? r_row : '0);

    always_comb begin
        n_row    = r_row;
        n_pend   = r_pend;
        n_done   = r_done;
        n_queued = r_queued;
        n_prio   = r_prio;
        if (i_ctl.clr) begin
            n_row[i_sel] = 1'b0;
            if (sel_me) begin
                n_row    = '0;
                n_pend   = '0;
                n_done   = 1'b0;
                n_queued = 1'b0;
                n_prio   = '0;
            end
        end
        if (i_ctl.set_prio && sel_me) begin
            n_prio = i_prio;
        end
        if (i_ctl.add_edge) begin
            if (sel_me) begin
                n_row[i_col] = 1'b1;
            end
            if (col_me) begin
                n_pend = r_pend + 4'd1;
            end
        end
        if (i_ctl.set_done && sel_me) begin
            n_done = 1'b1;
        end
        if (i_ctl.q_clr && sel_me) begin
            n_queued = 1'b0;
        end
        if (i_ctl.dec && col_me) begin
            n_pend = r_pend - 4'd1;
        end
        if (i_ctl.q_set && col_me) begin
            n_queued = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_pend   <= '0;
            r_done   <= 1'b0;
            r_queued <= 1'b0;
            r_prio   <= '0;
        end else begin
            r_row    <= n_row;
            r_pend   <= n_pend;
            r_done   <= n_done;
            r_queued <= n_queued;
            r_prio   <= n_prio;
        end
    end

    assign o_row    = r_row;
    assign o_pend   = r_pend;
    assign o_done   = r_done;
    assign o_queued = r_queued;
    assign o_prio   = r_prio;

endmodule

@@ design/dtds_queue_cell.sv @@
// ----------------------------------------------------------------------------
// dtds_queue_cell
// One slot of the ready queue; slots shift toward or away from the head.
// ----------------------------------------------------------------------------
module dtds_queue_cell #(
    parameter int NODE_COUNT = dtds_pkg::NODE_COUNT_DEF,
    parameter int IDX        = 0
) (
    input  logic                            i_clk,
    input  dtds_pkg::t_queue_ctl            i_ctl,
    input  logic [$clog2(NODE_COUNT+1)-1:0] i_len,
    input  logic signed [7:0]               i_w,
    input  logic [$clog2(NODE_COUNT)-1:0]   i_node,
    input  logic [$clog2(NODE_COUNT)-1:0]   i_prev_node,
    input  logic signed [7:0]               i_prev_prio,
    input  logic                            i_prev_ge,
    input  logic [$clog2(NODE_COUNT)-1:0]   i_next_node,
    input  logic signed [7:0]               i_next_prio,
    input  logic                            i_hit,
    output logic [$clog2(NODE_COUNT)-1:0]   o_node,
    output logic signed [7:0]               o_prio,
    output logic                            o_ge,
    output logic                            o_hit
);
    localparam int IW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);

    logic [IW-1:0]     r_node, n_node;
    logic signed [7:0] r_prio, n_prio;
    logic              slot_valid;

    assign slot_valid = (LW'(IDX) < i_len);
    assign o_ge  = slot_valid && (r_prio >= i_w);
    // Once a slot holds the removed node, it and every later slot pull from behind.
    assign o_hit = i_hit || (i_ctl.rm_node && slot_valid && (r_node == i_node));

    always_comb begin
        n_node = r_node;
        n_prio = r_prio;
        if (i_ctl.ins) begin
            if (!o_ge && (LW'(IDX) <= i_len)) begin
                if (i_prev_ge) begin
                    n_node = i_node;
                    n_prio = i_w;
                end else begin
                    n_node = i_prev_node;
                    n_prio = i_prev_prio;
                end
            end
        end else if (o_hit) begin
            n_node = i_next_node;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_prio <= n_prio;
    end

    assign o_node = r_node;
    assign o_prio = r_prio;

endmodule

@@ design/dag_task_dependency_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// dag_task_dependency_scheduler_unit
// Task-graph scheduler: node cells hold the graph, queue cells the ready list.
// ----------------------------------------------------------------------------
//  channel   | ports                         | handshake
//  ----------+-------------------------------+---------------------------------
//  command   | start, busy, i_item           | word taken when start && !busy
//  result    | o_strobe, o_result            | one cycle per word, no stall
//
// Clear, set priority and submit complete in the idle state. Add edge does too
// for an existing edge, else it runs rounds of the reach search until a round
// adds nothing. Dispatch and run step through the release state: the child
// release walks one node cell per cycle. The result word is registered: it
// follows the command's end, while the next command may already be taken.
// Reset is synchronous; it clears graph state and queue length, not slot data.
module dag_task_dependency_scheduler_unit #(
    parameter int NODE_COUNT = dtds_pkg::NODE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dtds_pkg::t_item   i_item,
    output logic              o_strobe,
    output dtds_pkg::t_result o_result
);
    localparam int IW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);

    dtds_pkg::t_state     r_state, n_state;
    logic [IW-1:0]        r_n, n_n, r_c, n_c, r_h, n_h, r_cnt, n_cnt;
    logic [NODE_COUNT-1:0] r_reach, n_reach;
    logic [LW-1:0]        r_qlen, n_qlen;
    logic                 r_disp, n_disp;
    logic                 r_strobe, n_strobe;
    dtds_pkg::t_result    r_res, n_res;

    dtds_pkg::t_cell_ctl  ctl;
    dtds_pkg::t_queue_ctl qctl;
    logic [IW-1:0]        sel, col, q_tgt;
    logic signed [7:0]    cell_prio, q_w;

    logic [NODE_COUNT-1:0] acc [NODE_COUNT+1];
    logic [NODE_COUNT-1:0] row_v [NODE_COUNT];
    logic [3:0]            pend_v [NODE_COUNT];
    logic [NODE_COUNT-1:0] done_v, queued_v;
    logic signed [7:0]     prio_v [NODE_COUNT];

    logic [IW-1:0]         q_node [NODE_COUNT];
    logic signed [7:0]     q_prio [NODE_COUNT];
    logic [NODE_COUNT-1:0] q_ge, q_hit;

    logic [IW-1:0]         in_n, in_c;
    logic                  in_ok;
    logic [NODE_COUNT-1:0] reach_nxt;

    assign acc[0] = '0;

    for (genvar i = 0; i < NODE_COUNT; i++) begin : g_node
        dtds_node_cell #(
            .NODE_COUNT (NODE_COUNT),
            .IDX        (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_sel       (sel),
            .i_col       (col),
            .i_prio      (cell_prio),
            .i_reach_bit (r_reach[i]),
            .i_acc       (acc[i]),
            .o_acc       (acc[i+1]),
            .o_row       (row_v[i]),
            .o_pend      (pend_v[i]),
            .o_done      (done_v[i]),
            .o_queued    (queued_v[i]),
            .o_prio      (prio_v[i])
        );
    end

    for (genvar i = 0; i < NODE_COUNT; i++) begin : g_queue
        logic [IW-1:0]     prev_node, next_node;
        logic signed [7:0] prev_prio, next_prio;
        logic              prev_ge, hit_in;
        if (i == 0) begin : g_head
            assign prev_node = '0;
            assign prev_prio = '0;
            assign prev_ge   = 1'b1;
            assign hit_in    = qctl.rm_head;
        end else begin : g_body
            assign prev_node = q_node[i-1];
            assign prev_prio = q_prio[i-1];
            assign prev_ge   = q_ge[i-1];
            assign hit_in    = q_hit[i-1];
        end
        if (i == NODE_COUNT - 1) begin : g_tail
            assign next_node = '0;
            assign next_prio = '0;
        end else begin : g_mid
            assign next_node = q_node[i+1];
            assign next_prio = q_prio[i+1];
        end
        dtds_queue_cell #(
            .NODE_COUNT (NODE_COUNT),
            .IDX        (i)
        ) u_slot (
            .i_clk       (i_clk),
            .i_ctl       (qctl),
            .i_len       (r_qlen),
            .i_w         (q_w),
            .i_node      (q_tgt),
            .i_prev_node (prev_node),
            .i_prev_prio (prev_prio),
            .i_prev_ge   (prev_ge),
            .i_next_node (next_node),
            .i_next_prio (next_prio),
            .i_hit       (hit_in),
            .o_node      (q_node[i]),
            .o_prio      (q_prio[i]),
            .o_ge        (q_ge[i]),
            .o_hit       (q_hit[i])
        );
    end

    assign in_n      = IW'(i_item.node);
    assign in_c      = IW'(i_item.other_node);
    assign reach_nxt = r_reach | acc[NODE_COUNT];
    assign in_ok     = (int'(i_item.node) < NODE_COUNT) &&
                       ((i_item.mode != dtds_pkg::MODE_ADD_EDGE) ||
                        (int'(i_item.other_node) < NODE_COUNT));

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_c       = r_c;
        n_h       = r_h;
        n_cnt     = r_cnt;
        n_reach   = r_reach;
        n_qlen    = r_qlen;
        n_disp    = r_disp;
        n_strobe  = 1'b0;
        n_res     = r_res;
        ctl       = '0;
        qctl      = '0;
        sel       = in_n;
        col       = in_c;
        q_tgt     = in_n;
        cell_prio = i_item.priority_req;
        q_w       = prio_v[in_n];

        unique case (r_state)
            dtds_pkg::S_IDLE: begin
                if (start) begin
                    n_strobe = 1'b1;
                    n_res    = '{status: dtds_pkg::ST_OK, out_node: 4'd0, out_valid: 1'b0};
                    if (!in_ok) begin
                        n_res.status = dtds_pkg::ST_IGNORED;
                    end else begin
                        unique case (dtds_pkg::t_mode'(i_item.mode))
                            dtds_pkg::MODE_CLEAR: begin
                                ctl.clr = 1'b1;
                                if (queued_v[in_n]) begin
                                    qctl.rm_node = 1'b1;
                                    n_qlen       = r_qlen - LW'(1);
                                end
                            end
                            dtds_pkg::MODE_SET_PRIO: begin
                                ctl.set_prio = 1'b1;
                            end
                            dtds_pkg::MODE_ADD_EDGE: begin
                                if (!row_v[in_n][in_c]) begin
                                    n_strobe = 1'b0;
                                    n_n      = in_n;
                                    n_c      = in_c;
                                    n_reach  = '0;
                                    n_reach[in_c] = 1'b1;
                                    n_state  = dtds_pkg::S_REACH;
                                end
                            end
                            dtds_pkg::MODE_SUBMIT: begin
                                if (pend_v[in_n] != 4'd0 || done_v[in_n]) begin
                                    n_res.status = dtds_pkg::ST_IGNORED;
                                end else if (!queued_v[in_n] &&
                                             r_qlen < LW'(NODE_COUNT)) begin
                                    ctl.q_set = 1'b1;
                                    col       = in_n;
                                    qctl.ins  = 1'b1;
                                    n_qlen    = r_qlen + LW'(1);
                                end
                            end
                            dtds_pkg::MODE_DISPATCH: begin
                                if (r_qlen == '0) begin
                                    n_res.status = dtds_pkg::ST_EMPTY;
                                end else begin
                                    n_strobe     = 1'b0;
                                    qctl.rm_head = 1'b1;
                                    n_qlen       = r_qlen - LW'(1);
                                    ctl.q_clr    = 1'b1;
                                    ctl.set_done = 1'b1;
                                    sel          = q_node[0];
                                    n_h          = q_node[0];
                                    n_disp       = 1'b1;
                                    n_cnt        = '0;
                                    n_state      = dtds_pkg::S_RELEASE;
                                end
                            end
                            dtds_pkg::MODE_RUN: begin
                                if (pend_v[in_n] != 4'd0 || done_v[in_n]) begin
                                    n_res.status = dtds_pkg::ST_IGNORED;
                                end else begin
                                    n_strobe     = 1'b0;
                                    ctl.q_clr    = 1'b1;
                                    ctl.set_done = 1'b1;
                                    if (queued_v[in_n]) begin
                                        qctl.rm_node = 1'b1;
                                        n_qlen       = r_qlen - LW'(1);
                                    end
                                    n_h     = in_n;
                                    n_disp  = 1'b0;
                                    n_cnt   = '0;
                                    n_state = dtds_pkg::S_RELEASE;
                                end
                            end
                            default: begin
                                n_res.status = dtds_pkg::ST_IGNORED;
                            end
                        endcase
                    end
                end
            end
            dtds_pkg::S_REACH: begin
                sel = r_n;
                col = r_c;
                // The reach set is complete once a round adds nothing.
                if (reach_nxt == r_reach) begin
                    n_strobe = 1'b1;
                    n_state  = dtds_pkg::S_IDLE;
                    n_res    = '{status: dtds_pkg::ST_OK, out_node: 4'd0, out_valid: 1'b0};
                    if (r_reach[r_n]) begin
                        n_res.status = dtds_pkg::ST_CYCLE;
                    end else begin
                        ctl.add_edge = 1'b1;
                    end
                end else begin
                    n_reach = reach_nxt;
                end
            end
            dtds_pkg::S_RELEASE: begin
                sel   = r_h;
                col   = r_cnt;
                q_tgt = r_cnt;
                q_w   = prio_v[r_cnt];
                if (row_v[r_h][r_cnt] && pend_v[r_cnt] != 4'd0) begin
                    ctl.dec = 1'b1;
                    if (pend_v[r_cnt] == 4'd1 && !done_v[r_cnt] && !queued_v[r_cnt] &&
                        r_qlen < LW'(NODE_COUNT)) begin
                        ctl.q_set = 1'b1;
                        qctl.ins  = 1'b1;
                        n_qlen    = r_qlen + LW'(1);
                    end
                end
                if (r_cnt == IW'(NODE_COUNT - 1)) begin
                    n_strobe = 1'b1;
                    n_state  = dtds_pkg::S_IDLE;
                    n_res    = '{status: dtds_pkg::ST_OK,
                                 out_node: r_disp ? 4'(r_h) : 4'd0,
                                 out_valid: r_disp};
                end else begin
                    n_cnt = r_cnt + IW'(1);
                end
            end
            default: begin
                n_state = dtds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dtds_pkg::S_IDLE;
            r_qlen   <= '0;
            r_strobe <= 1'b0;
            r_reach  <= '0;
        end else begin
            r_state  <= n_state;
            r_qlen   <= n_qlen;
            r_strobe <= n_strobe;
            r_reach  <= n_reach;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_c    <= n_c;
        r_h    <= n_h;
        r_cnt  <= n_cnt;
        r_disp <= n_disp;
        r_res  <= n_res;
    end

    assign busy     = (r_state != dtds_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`include "assert_macros.svh"

    `ASSERT_CLK(a_qlen_max, r_qlen <= LW'(NODE_COUNT))
    `ASSERT_CLK(a_qlen_matches_flags, $countones(queued_v) == int'(r_qlen))
    `ASSERT_IMPL(a_disp_ok, o_strobe && o_result.out_valid, o_result.status == dtds_pkg::ST_OK)
    `ASSERT_IMPL(a_release_no_strobe, r_state == dtds_pkg::S_RELEASE, !r_strobe)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the task-graph scheduler. Commands are driven at
// random pacing; a built-in model of the node table and ready queue predicts
// each result word, and a scoreboard compares them in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NN = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    class sched_scoreboard;
        logic [NN-1:0]    succ[NN];
        int unsigned      wait_cnt[NN];
        bit               fin[NN];
        bit               inq[NN];
        logic signed [7:0] prio[NN];
        int unsigned      rq_node[$];
        int               rq_prio[$];
        dtds_pkg::t_result pending_words[$];
        int               mismatches;
        int               words_checked;

        function void clear_all();
            for (int i = 0; i < NN; i++) begin
                succ[i] = '0; wait_cnt[i] = 0; fin[i] = 0; inq[i] = 0; prio[i] = 0;
            end
            rq_node.delete(); rq_prio.delete();
        endfunction

        function void drop_from_queue(int unsigned n);
            if (!inq[n]) return;
            foreach (rq_node[i]) begin
                if (rq_node[i] == n) begin
                    rq_node.delete(i); rq_prio.delete(i);
                    break;
                end
            end
            inq[n] = 0;
        endfunction

        function void make_ready(int unsigned n);
            int pos;
            pos = 0;
            if (inq[n] || rq_node.size() >= NN) return;
            while (pos < rq_node.size() && rq_prio[pos] >= int'(prio[n])) pos++;
            rq_node.insert(pos, n);
            rq_prio.insert(pos, int'(prio[n]));
            inq[n] = 1;
        endfunction

        function void complete(int unsigned n);
            fin[n] = 1;
            for (int c = 0; c < NN; c++) begin
                if (!succ[n][c] || wait_cnt[c] == 0) continue;
                wait_cnt[c]--;
                if (wait_cnt[c] == 0 && !fin[c]) make_ready(c);
            end
        endfunction

        function bit reaches(int unsigned src, int unsigned dst);
            logic [NN-1:0] seen, grown;
            seen = '0;
            seen[src] = 1'b1;
            for (int r = 0; r < NN; r++) begin
                grown = seen;
                for (int i = 0; i < NN; i++) if (seen[i]) grown |= succ[i];
                if (grown == seen) break;
                seen = grown;
            end
            return seen[dst];
        endfunction

        function void note_command(dtds_pkg::t_item it);
            dtds_pkg::t_result r;
            int unsigned n, c, h;
            r = '{status: dtds_pkg::ST_OK, out_node: 4'd0, out_valid: 1'b0};
            n = it.node;
            c = it.other_node;
            case (it.mode)
                dtds_pkg::MODE_CLEAR: begin
                    drop_from_queue(n);
                    succ[n] = '0;
                    for (int i = 0; i < NN; i++) succ[i][n] = 1'b0;
                    wait_cnt[n] = 0; fin[n] = 0; prio[n] = 0;
                end
                dtds_pkg::MODE_SET_PRIO: prio[n] = it.priority_req;
                dtds_pkg::MODE_ADD_EDGE: begin
                    if (succ[n][c]) r.status = dtds_pkg::ST_OK;
                    else if (reaches(c, n)) r.status = dtds_pkg::ST_CYCLE;
                    else begin
                        succ[n][c] = 1'b1;
                        wait_cnt[c] = (wait_cnt[c] + 1) & 4'hF;
                    end
                end
                dtds_pkg::MODE_SUBMIT: begin
                    if (wait_cnt[n] != 0 || fin[n]) r.status = dtds_pkg::ST_IGNORED;
                    else make_ready(n);
                end
                dtds_pkg::MODE_DISPATCH: begin
                    if (rq_node.size() == 0) r.status = dtds_pkg::ST_EMPTY;
                    else begin
                        h = rq_node.pop_front();
                        void'(rq_prio.pop_front());
                        inq[h] = 0;
                        complete(h);
                        r.out_node = h[3:0];
                        r.out_valid = 1'b1;
                    end
                end
                dtds_pkg::MODE_RUN: begin
                    if (wait_cnt[n] != 0 || fin[n]) r.status = dtds_pkg::ST_IGNORED;
                    else begin
                        drop_from_queue(n);
                        complete(n);
                    end
                end
                default: r.status = dtds_pkg::ST_IGNORED;
            endcase
            pending_words.push_back(r);
        endfunction

        function void check_word(dtds_pkg::t_result got);
            dtds_pkg::t_result exp_r;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
                return;
            end
            exp_r = pending_words.pop_front();
            words_checked++;
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    dtds_pkg::t_item   i_item;
    logic    o_strobe;
    dtds_pkg::t_result o_result;

    sched_scoreboard sb;
    int      idle_pct;
    int      quiet_cycles = 0;
    int      sent;
    int      mode_hits[8];

    dag_task_dependency_scheduler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) quiet_cycles <= 0;
        else if (i_rst_n && o_strobe) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_strobe) sb.check_word(o_result);
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Holds start up until the word is taken; sender idles at random first.
    // Start stays high after a word so that back-to-back words need no gap.
    task automatic send_word(dtds_pkg::t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(it);
        mode_hits[it.mode]++;
        sent++;
    endtask

    task automatic send_fields(int m, int n, int c, int p);
        dtds_pkg::t_item it;
        it.mode = m[2:0];
        it.node = n[3:0];
        it.other_node = c[3:0];
        it.priority_req = p[7:0];
        send_word(it);
    endtask

    // Mostly graph-building and dispatching traffic over nodes 0 to span.
    task automatic send_random(int span);
        int m, r;
        r = $urandom_range(99);
        if (r < 8) m = dtds_pkg::MODE_CLEAR;
        else if (r < 20) m = dtds_pkg::MODE_SET_PRIO;
        else if (r < 45) m = dtds_pkg::MODE_ADD_EDGE;
        else if (r < 65) m = dtds_pkg::MODE_SUBMIT;
        else if (r < 85) m = dtds_pkg::MODE_DISPATCH;
        else if (r < 96) m = dtds_pkg::MODE_RUN;
        else m = $urandom_range(7);
        send_fields(m, $urandom_range(span), $urandom_range(span), $urandom);
    endtask

    initial begin
        sb = new();
        sb.clear_all();
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        sent = 0;
        for (int i = 0; i < 8; i++) mode_hits[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extremes, self edge, cycle, duplicates, bad modes.
        send_fields(dtds_pkg::MODE_DISPATCH, 0, 0, 0);
        send_fields(dtds_pkg::MODE_SET_PRIO, 15, 0, 127);
        send_fields(dtds_pkg::MODE_SET_PRIO, 3, 0, -128);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 5, 5, 0);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 0, 15, 0);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 0, 15, 0);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 15, 0, 0);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 3, 15, 0);
        send_fields(dtds_pkg::MODE_SUBMIT, 15, 0, 0);
        send_fields(dtds_pkg::MODE_SUBMIT, 0, 0, 0);
        send_fields(dtds_pkg::MODE_SUBMIT, 0, 0, 0);
        send_fields(dtds_pkg::MODE_SUBMIT, 3, 0, 0);
        send_fields(dtds_pkg::MODE_SET_PRIO, 0, 0, -1);
        send_fields(dtds_pkg::MODE_DISPATCH, 0, 0, 0);
        send_fields(dtds_pkg::MODE_RUN, 15, 0, 0);
        send_fields(dtds_pkg::MODE_RUN, 3, 0, 0);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 3, 7, 0);
        send_fields(dtds_pkg::MODE_RUN, 3, 0, 0);
        send_fields(dtds_pkg::MODE_DISPATCH, 0, 0, 0);
        send_fields(dtds_pkg::MODE_DISPATCH, 0, 0, 0);
        send_fields(dtds_pkg::MODE_CLEAR, 15, 0, 0);
        send_fields(dtds_pkg::MODE_CLEAR, 3, 0, 0);
        send_fields(6, 15, 15, 0);
        send_fields(7, 0, 0, 85);
        send_fields(dtds_pkg::MODE_ADD_EDGE, 10, 5, -86);

        // Random phases with different pacing; narrow spans stress the graph.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 74 : (ph == 3) ? 26 : 0;
            for (int k = 0; k < 460; k++)
                send_random((k % 3 == 0) ? 15 : (k % 3 == 1) ? 5 : 9);
        end
        start <= 1'b0;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d commands; %0d result words checked.", sent, sb.words_checked);
        $display("Mode counts: clr %0d prio %0d edge %0d submit %0d disp %0d run %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5]);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end
endmodule
